// ===== design/spq_pkg.sv =====
package spq_pkg;

	// Default sizing of the queue
	localparam int CAPACITY_DEFAULT      = 16;
	localparam int TAG_BITS_DEFAULT      = 16;
	localparam int PRIORITY_BITS_DEFAULT = 8;

	// Fixed widths of the item fields on the ports
	localparam int PRIORITY_PORT_BITS  = 8;
	localparam int TAG_PORT_BITS       = 16;
	localparam int STATUS_BITS         = 2;
	localparam int OCCUPANCY_PORT_BITS = 5;

	typedef logic [STATUS_BITS-1:0] status_t;

	// Operation codes
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	// Result status codes
	localparam status_t STATUS_ENQUEUED = 2'd0;
	localparam status_t STATUS_FULL     = 2'd1;
	localparam status_t STATUS_DEQUEUED = 2'd2;
	localparam status_t STATUS_EMPTY    = 2'd3;

endpackage

// ===== design/sorted_priority_queue_unit.sv =====
// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------------------
// in       in_valid / in_ready  op, priority_req, payload_tag
// out      out_valid/ out_ready status, out_priority, out_tag, occupancy
//
// Entries sit in a ring in one memory (one write port, one registered read
// port), sorted from head to tail. A full enqueue, an empty dequeue or an
// enqueue into an empty queue goes straight to the result; a dequeue first
// reads the head; an enqueue into a non-empty queue walks the ring from the
// tail through the single read port, one entry a cycle, moving each entry of
// greater or equal priority up one slot before it writes the new entry.
// One item is worked on at a time; in_ready is high only while idle. A result
// waits in the output register while the next item is taken in.
// Reset empties the queue; the memory itself is not cleared.
module sorted_priority_queue_unit #(
	parameter int CAPACITY      = spq_pkg::CAPACITY_DEFAULT,
	parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEFAULT,
	parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEFAULT
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic                                        op,
	input  logic [spq_pkg::PRIORITY_PORT_BITS-1:0]      priority_req,
	input  logic [spq_pkg::TAG_PORT_BITS-1:0]           payload_tag,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output spq_pkg::status_t                            status,
	output logic [spq_pkg::PRIORITY_PORT_BITS-1:0]      out_priority,
	output logic [spq_pkg::TAG_PORT_BITS-1:0]           out_tag,
	output logic [spq_pkg::OCCUPANCY_PORT_BITS-1:0]     occupancy
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = AW + 1;
	localparam int W  = PRIORITY_BITS + TAG_BITS;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEQ   = 3'd1;
	localparam logic [2:0] S_INS   = 3'd2;
	localparam logic [2:0] S_PLACE = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
		return (i == AW'(CAPACITY - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
		return (i == '0) ? AW'(CAPACITY - 1) : i - 1'b1;
	endfunction

	logic [2:0]               state_q;
	logic [AW-1:0]            head_q;
	logic [CW-1:0]            count_q;
	logic [AW-1:0]            cur_q;
	logic [CW-1:0]            left_q;
	logic                     out_valid_q;

	logic [PRIORITY_BITS-1:0] pri_q;
	logic [TAG_BITS-1:0]      tag_q;
	spq_pkg::status_t         res_status_q;
	logic [PRIORITY_BITS-1:0] res_pri_q;
	logic [TAG_BITS-1:0]      res_tag_q;
	spq_pkg::status_t         out_status_q;
	logic [PRIORITY_BITS-1:0] out_pri_q;
	logic [TAG_BITS-1:0]      out_tag_q;
	logic [CW-1:0]            occ_q;

	logic [W-1:0]             mem [CAPACITY];
	logic [W-1:0]             rd_data_q;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [W-1:0]             wr_data;

	logic                     in_fire;
	logic                     out_load;
	logic                     is_empty;
	logic                     is_full;
	logic                     shift;
	logic [PRIORITY_BITS-1:0] pri_in;
	logic [TAG_BITS-1:0]      tag_in;
	logic [PRIORITY_BITS-1:0] rd_pri;
	logic [SW-1:0]            tail_sum;
	logic [AW-1:0]            last_idx;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(CAPACITY));
	assign pri_in   = PRIORITY_BITS'(priority_req);
	assign tag_in   = TAG_BITS'(payload_tag);
	assign rd_pri   = rd_data_q[W-1:TAG_BITS];
	assign shift    = (rd_pri >= pri_q);

	// Locate the youngest entry: head + count - 1, wrapped into the ring
	assign tail_sum = SW'(head_q) + SW'(count_q) - SW'(1);
	assign last_idx = (tail_sum >= SW'(CAPACITY)) ? AW'(tail_sum - SW'(CAPACITY))
	                                              : AW'(tail_sum);

	// Drive the memory ports
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = head_q;
		wr_data = {pri_q, tag_q};
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (op == spq_pkg::OP_DEQUEUE) begin
						rd_en = !is_empty;
					end else if (is_empty) begin
						wr_en   = 1'b1;
						wr_data = {pri_in, tag_in};
					end else if (!is_full) begin
						rd_en   = 1'b1;
						rd_addr = last_idx;
					end
				end
			end
			S_INS: begin
				// Move a greater-or-equal entry up one slot, else drop the new one in
				wr_en   = 1'b1;
				wr_addr = idx_inc(cur_q);
				if (shift) begin
					wr_data = rd_data_q;
					if (left_q != CW'(1)) begin
						rd_en   = 1'b1;
						rd_addr = idx_dec(cur_q);
					end
				end
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = cur_q;
			end
			default: begin
			end
		endcase
	end

	// Entry memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			cur_q       <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new result, else drop the accepted one
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (op == spq_pkg::OP_DEQUEUE) begin
							state_q <= is_empty ? S_FIN : S_DEQ;
						end else if (is_full) begin
							state_q <= S_FIN;
						end else if (is_empty) begin
							count_q <= CW'(1);
							state_q <= S_FIN;
						end else begin
							cur_q   <= last_idx;
							left_q  <= count_q;
							state_q <= S_INS;
						end
					end
				end
				S_DEQ: begin
					head_q  <= idx_inc(head_q);
					count_q <= count_q - 1'b1;
					state_q <= S_FIN;
				end
				S_INS: begin
					if (!shift) begin
						count_q <= count_q + 1'b1;
						state_q <= S_FIN;
					end else if (left_q == CW'(1)) begin
						state_q <= S_PLACE;
					end else begin
						cur_q  <= idx_dec(cur_q);
						left_q <= left_q - 1'b1;
					end
				end
				S_PLACE: begin
					count_q <= count_q + 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the item and build the result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pri_q     <= pri_in;
			tag_q     <= tag_in;
			res_pri_q <= '0;
			res_tag_q <= '0;
			if (op == spq_pkg::OP_DEQUEUE) begin
				res_status_q <= is_empty ? spq_pkg::STATUS_EMPTY : spq_pkg::STATUS_DEQUEUED;
			end else begin
				res_status_q <= is_full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_ENQUEUED;
			end
		end
		if (state_q == S_DEQ) begin
			res_pri_q <= rd_pri;
			res_tag_q <= rd_data_q[TAG_BITS-1:0];
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_pri_q    <= res_pri_q;
			out_tag_q    <= res_tag_q;
			occ_q        <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign out_priority = spq_pkg::PRIORITY_PORT_BITS'(out_pri_q);
	assign out_tag      = spq_pkg::TAG_PORT_BITS'(out_tag_q);
	assign occupancy    = spq_pkg::OCCUPANCY_PORT_BITS'(occ_q);

endmodule

// ===== design/spq_checker.sv =====
module spq_checker #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input spq_pkg::status_t                        status,
	input logic [spq_pkg::PRIORITY_PORT_BITS-1:0]  out_priority,
	input logic [spq_pkg::TAG_PORT_BITS-1:0]       out_tag,
	input logic [spq_pkg::OCCUPANCY_PORT_BITS-1:0] occupancy
);

	// Occupancy never passes the capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occupancy <= spq_pkg::OCCUPANCY_PORT_BITS'(CAPACITY)))
		else $error("occupancy above capacity");

	// Only a dequeue returns a priority or a tag
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != spq_pkg::STATUS_DEQUEUED)
		|-> (out_priority == '0 && out_tag == '0))
		else $error("nonzero data on a result that is not a dequeue");

	// A dropped enqueue sees a full queue, a failed dequeue an empty one
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == spq_pkg::STATUS_FULL)
		|-> (occupancy == spq_pkg::OCCUPANCY_PORT_BITS'(CAPACITY)))
		else $error("enqueue dropped below capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == spq_pkg::STATUS_EMPTY) |-> (occupancy == '0))
		else $error("empty status with stored entries");

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status)
		&& $stable(out_priority) && $stable(out_tag) && $stable(occupancy)))
		else $error("result changed while stalled");

endmodule

bind sorted_priority_queue_unit spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.out_priority (out_priority),
	.out_tag      (out_tag),
	.occupancy    (occupancy)
);
